// ===== design/ahb_lite_bus_master_macros.svh =====
// ----------------------------------------------------------------------------
// AHB-Lite bus master assertion macros
// Concurrent assertion helpers for the bus master. They sample on clk_i and
// are disabled while rst_ni is low. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef AHB_LITE_BUS_MASTER_MACROS_SVH
`define AHB_LITE_BUS_MASTER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define AHBLM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define AHBLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define AHBLM_ASSERT_IMPL(label, ante, cons, msg)
`define AHBLM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== design/ahblm_pkg.sv =====
// ----------------------------------------------------------------------------
// AHB-Lite bus master package
// Bus codes, command codes, sizes and the word types shared by the modules.
// ----------------------------------------------------------------------------
package ahblm_pkg;

  localparam int unsigned MaxBeats = 256;
  localparam int unsigned BeatsW   = $clog2(MaxBeats + 1);
  localparam logic [31:0] AddrStep = 32'd4;

  localparam logic [1:0] TransIdle   = 2'd0;
  localparam logic [1:0] TransNonseq = 2'd2;
  localparam logic [1:0] TransSeq    = 2'd3;
  localparam logic       BurstSingle = 1'b0;
  localparam logic       BurstIncr   = 1'b1;

  typedef enum logic [2:0] {
    CMD_NONE      = 3'd0,
    CMD_RD_SINGLE = 3'd1,
    CMD_WR_SINGLE = 3'd2,
    CMD_RD_BURST  = 3'd3,
    CMD_WR_BURST  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_FIRST = 3'b010,
    PH_NEXT  = 3'b100
  } phase_e;

  // One bus clock worth of input.
  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] start_address;
    logic [8:0]  beat_count;
    logic [31:0] write_word;
    logic        slave_ready;
    logic [31:0] slave_rdata;
  } in_t;

  // One bus clock worth of result.
  typedef struct packed {
    logic [31:0] bus_address;
    logic [1:0]  transfer_type;
    logic        is_write;
    logic        burst_kind;
    logic [31:0] bus_wdata;
    logic        read_valid;
    logic [31:0] read_word;
    logic        write_taken;
    logic        busy_res;
    logic        last_beat;
  } res_t;

endpackage

// ===== design/ahblm_core.sv =====
// ----------------------------------------------------------------------------
// AHB-Lite bus master core
// Holds the address and data phase state and works out one bus clock.
// ----------------------------------------------------------------------------
module ahblm_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  ahblm_pkg::in_t   in_i,
  output ahblm_pkg::res_t  res_o
);

  ahblm_pkg::phase_e               phase_q, phase_d;
  logic [31:0]                     addr_q, addr_d;
  logic [ahblm_pkg::BeatsW-1:0]    beats_q, beats_d;
  logic                            wdir_q, wdir_d;
  logic                            incr_q, incr_d;
  logic [31:0]                     wdata_q, wdata_d;
  logic                            dpend_q, dpend_d;
  logic                            dwrite_q, dwrite_d;
  logic                            dlast_q, dlast_d;

  logic                            cmd_ok;
  logic                            is_burst;
  logic                            addr_active;
  logic [31:0]                     count32;
  logic [31:0]                     clamp32;
  ahblm_pkg::phase_e               ph_cur;
  logic [31:0]                     addr_cur;
  logic [ahblm_pkg::BeatsW-1:0]    beats_cur;
  logic                            wdir_cur;
  logic                            incr_cur;

  always_comb begin
    cmd_ok   = in_i.cmd inside {[ahblm_pkg::CMD_RD_SINGLE : ahblm_pkg::CMD_WR_BURST]};
    is_burst = (in_i.cmd == ahblm_pkg::CMD_RD_BURST) || (in_i.cmd == ahblm_pkg::CMD_WR_BURST);
    count32  = 32'(in_i.beat_count);
    clamp32  = count32;
    if (count32 == 32'd0) begin
      clamp32 = 32'd1;
    end else if (count32 > 32'(ahblm_pkg::MaxBeats)) begin
      clamp32 = 32'(ahblm_pkg::MaxBeats);
    end

    // A new command is only taken when no address phase is owed.
    ph_cur    = phase_q;
    addr_cur  = addr_q;
    beats_cur = beats_q;
    wdir_cur  = wdir_q;
    incr_cur  = incr_q;
    addr_active = 1'b0;
    if (phase_q != ahblm_pkg::PH_IDLE) begin
      addr_active = 1'b1;
    end else if (cmd_ok) begin
      addr_active = 1'b1;
      ph_cur      = ahblm_pkg::PH_FIRST;
      addr_cur    = in_i.start_address;
      wdir_cur    = (in_i.cmd == ahblm_pkg::CMD_WR_SINGLE) ||
                    (in_i.cmd == ahblm_pkg::CMD_WR_BURST);
      incr_cur    = is_burst ? ahblm_pkg::BurstIncr : ahblm_pkg::BurstSingle;
      beats_cur   = is_burst ? clamp32[ahblm_pkg::BeatsW-1:0]
                             : ahblm_pkg::BeatsW'(1);
    end

    res_o = '0;
    res_o.busy_res = (phase_q != ahblm_pkg::PH_IDLE);
    if (addr_active) begin
      res_o.bus_address   = addr_cur;
      res_o.transfer_type = (ph_cur == ahblm_pkg::PH_FIRST) ? ahblm_pkg::TransNonseq
                                                             : ahblm_pkg::TransSeq;
      res_o.is_write      = wdir_cur;
      res_o.burst_kind    = incr_cur;
    end

    phase_d  = ph_cur;
    addr_d   = addr_cur;
    beats_d  = beats_cur;
    wdir_d   = wdir_cur;
    incr_d   = incr_cur;
    wdata_d  = wdata_q;
    dpend_d  = dpend_q;
    dwrite_d = dwrite_q;
    dlast_d  = dlast_q;

    // The pending data phase completes when the slave is ready.
    if (dpend_q) begin
      if (dwrite_q) begin
        res_o.bus_wdata = wdata_q;
      end
      if (in_i.slave_ready) begin
        if (!dwrite_q) begin
          res_o.read_valid = 1'b1;
          res_o.read_word  = in_i.slave_rdata;
        end
        res_o.last_beat = dlast_q;
        dpend_d = 1'b0;
      end
    end

    // An accepted address phase becomes the next data phase.
    if (addr_active && in_i.slave_ready) begin
      dpend_d  = 1'b1;
      dwrite_d = wdir_cur;
      dlast_d  = (beats_cur <= ahblm_pkg::BeatsW'(1));
      if (wdir_cur) begin
        wdata_d           = in_i.write_word;
        res_o.write_taken = 1'b1;
      end
      if (beats_cur != '0) begin
        beats_d = beats_cur - ahblm_pkg::BeatsW'(1);
      end
      addr_d  = addr_cur + ahblm_pkg::AddrStep;
      phase_d = (beats_d == '0) ? ahblm_pkg::PH_IDLE : ahblm_pkg::PH_NEXT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ahblm_pkg::PH_IDLE;
      addr_q   <= '0;
      beats_q  <= '0;
      wdir_q   <= 1'b0;
      incr_q   <= 1'b0;
      wdata_q  <= '0;
      dpend_q  <= 1'b0;
      dwrite_q <= 1'b0;
      dlast_q  <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      addr_q   <= addr_d;
      beats_q  <= beats_d;
      wdir_q   <= wdir_d;
      incr_q   <= incr_d;
      wdata_q  <= wdata_d;
      dpend_q  <= dpend_d;
      dwrite_q <= dwrite_d;
      dlast_q  <= dlast_d;
    end
  end

endmodule

// ===== design/ahb_lite_bus_master.sv =====
// ----------------------------------------------------------------------------
// AHB-Lite bus master
// Stream-wrapped AHB-Lite master: one input word per bus clock, one result
// word back with the HADDR/HTRANS/HWRITE/HBURST/HWDATA drive and read data.
// ----------------------------------------------------------------------------
// Usage:
// Each slave-side word is one bus clock. It carries an optional command
// (single or incrementing burst, read or write, with start address and beat
// count), the write data for a beat entering its data phase, and the slave's
// HREADY and HRDATA. For every accepted word exactly one master-side word is
// produced, holding the bus drive for that clock, completed read data, the
// write-data-consumed flag and the busy flag; tlast marks the final beat of
// a transfer completing.
// The result of an accepted word is registered and valid in the cycle
// after it is accepted. Throughput is one word per cycle while results are
// taken, set by the single phase-state register every bus clock updates.
// Reset puts the master in the idle phase with no data phase pending and
// empties the result register.
// When the receiver stalls, the result is held in the output register and
// the slave side stops accepting until it is taken; a word can be accepted
// in the same cycle in which the held result leaves.
// ----------------------------------------------------------------------------
`include "ahb_lite_bus_master_macros.svh"

module ahb_lite_bus_master (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata, lowest bit up: cmd[2:0], start_address[34:3], beat_count[43:35],
  // write_word[75:44], slave_ready[76], slave_rdata[108:77], zero[111:109].
  input  logic [111:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata, lowest bit up: bus_address[31:0], transfer_type[33:32],
  // is_write[34], burst_kind[35], bus_wdata[67:36], read_valid[68],
  // read_word[100:69], write_taken[101], busy_res[102], zero[103].
  output logic [103:0] m_axis_tdata_o,
  // last_beat.
  output logic         m_axis_tlast_o
);

  ahblm_pkg::in_t  in_word;
  ahblm_pkg::res_t res_comb;
  ahblm_pkg::res_t res_q;
  logic            out_valid_q;
  logic            in_accept;

  // Unpack the slave-side word.
  assign in_word.cmd           = s_axis_tdata_i[2:0];
  assign in_word.start_address = s_axis_tdata_i[34:3];
  assign in_word.beat_count    = s_axis_tdata_i[43:35];
  assign in_word.write_word    = s_axis_tdata_i[75:44];
  assign in_word.slave_ready   = s_axis_tdata_i[76];
  assign in_word.slave_rdata   = s_axis_tdata_i[108:77];

  // The output register accepts a new result when empty or being drained.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  ahblm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (in_accept),
    .in_i   (in_word),
    .res_o  (res_comb)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      res_q <= res_comb;
    end
  end

  // Pack the master-side word.
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = res_q.last_beat;
  assign m_axis_tdata_o  = {1'b0, res_q.busy_res, res_q.write_taken, res_q.read_word,
                            res_q.read_valid, res_q.bus_wdata, res_q.burst_kind,
                            res_q.is_write, res_q.transfer_type, res_q.bus_address};

  // A held result must never be overwritten by a new word.
  `AHBLM_ASSERT_IMPL(a_no_overwrite, m_axis_tvalid_o && !m_axis_tready_i, !s_axis_tready_o, "result overwritten while stalled")
  // Every accepted word yields a result on the next cycle.
  `AHBLM_ASSERT_NEXT(a_result_follows, in_accept, m_axis_tvalid_o, "accepted word produced no result")
  // Busy means an address phase is being driven.
  `AHBLM_ASSERT_IMPL(a_busy_drives, m_axis_tvalid_o && res_q.busy_res, res_q.transfer_type != ahblm_pkg::TransIdle, "busy without an address phase")
  // Write data is only consumed by a write address phase. A pipelined read
  // data phase may complete in the same cycle.
  `AHBLM_ASSERT_IMPL(a_taken_is_write, m_axis_tvalid_o && res_q.write_taken, res_q.is_write, "write data taken outside a write")

endmodule
